/* design/mhtq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared types, codes and default sizes of the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int HEAP_DEPTH_DEF = 32;
  localparam int ID_COUNT_DEF   = 1024;

  localparam int ID_W  = 10;
  localparam int TMO_W = 16;
  localparam int EX_W  = 32;

  // Request functions.
  localparam logic [1:0] F_ADD    = 2'd0;
  localparam logic [1:0] F_ADJUST = 2'd1;
  localparam logic [1:0] F_TICK   = 2'd2;
  localparam logic [1:0] F_CLEAR  = 2'd3;

  // Result kinds.
  localparam logic [1:0] K_DONE      = 2'd0;
  localparam logic [1:0] K_EXPIRED   = 2'd1;
  localparam logic [1:0] K_NOT_FOUND = 2'd2;
  localparam logic [1:0] K_FULL      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [EX_W-1:0] ex;
  } entry_t;

  // True when expiry a comes strictly before expiry b on the wrapped clock.
  function automatic logic earlier(input logic [EX_W-1:0] a, input logic [EX_W-1:0] b);
    logic [EX_W-1:0] diff;
    diff = a - b;
    return diff[EX_W-1];
  endfunction

endpackage

/* design/min_heap_timer_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_timer_queue_unit
// Timer queue on an indexed binary min-heap held in a slot memory.
// ----------------------------------------------------------------------------
// One request is worked at a time. After reset the id map is swept once, one
// entry a cycle, before the first request is taken. Each heap level visited
// by a sift takes a registered memory read, then a compare and write back.
// The moving entry is held in a register while the sift walks, so each level
// needs one slot write.
module min_heap_timer_queue_unit
  import mhtq_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int ID_COUNT   = ID_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] timer_id, [25:10] timeout_ms
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] expired_id, [10] pending, [26:11] next_due_ms
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int CW  = $clog2(HEAP_DEPTH + 1);
  localparam int PAW = $clog2(ID_COUNT);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LK1  = 4'd2;
  localparam logic [3:0] S_LK2  = 4'd3;
  localparam logic [3:0] S_UP   = 4'd4;
  localparam logic [3:0] S_UP2  = 4'd5;
  localparam logic [3:0] S_DN   = 4'd6;
  localparam logic [3:0] S_DN2  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;
  localparam logic [3:0] S_POPR = 4'd9;
  localparam logic [3:0] S_POP  = 4'd10;
  localparam logic [3:0] S_FIN0 = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0]      state_r, state_nxt;
  logic [PAW-1:0]  clr_r, clr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [EX_W-1:0] now_r, now_nxt;
  logic [1:0]      func_r, func_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [EX_W-1:0] ex_r, ex_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic            pop_r, pop_nxt;
  entry_t          item_r, item_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  logic            out_pend_r, out_pend_nxt;
  logic [15:0]     out_next_r, out_next_nxt;
  logic            out_last_r, out_last_nxt;

  logic           h_rd_en, h_we;
  logic [HAW-1:0] h_ra, h_rb, h_wa;
  entry_t         h_rda, h_rdb, h_wd;
  logic           p_rd_en, p_we;
  logic [PAW-1:0] p_ra, p_wa;
  logic [HAW-1:0] p_rd, p_wd;

  logic            out_free;
  logic [31:0]     in_id_ext, rda_id_ext, item_id_ext;
  logic [CW:0]     left_c, right_c;
  logic [CW-1:0]   parent_c;
  logic [EX_W-1:0] diff_c;
  logic            right_pick;
  entry_t          child_c;

  mhtq_heap_mem #(.HEAP_DEPTH(HEAP_DEPTH), .HAW(HAW)) u_heap (
    .clk     (clk),
    .rd_en   (h_rd_en),
    .rda_addr(h_ra),
    .rdb_addr(h_rb),
    .rda_data(h_rda),
    .rdb_data(h_rdb),
    .wr_en   (h_we),
    .wr_addr (h_wa),
    .wr_data (h_wd)
  );

  mhtq_pos_mem #(.ID_COUNT(ID_COUNT), .PAW(PAW), .HAW(HAW)) u_pos (
    .clk    (clk),
    .rd_en  (p_rd_en),
    .rd_addr(p_ra),
    .rd_data(p_rd),
    .wr_en  (p_we),
    .wr_addr(p_wa),
    .wr_data(p_wd)
  );

  assign out_free    = !out_valid_r || out_tready;
  assign in_id_ext   = 32'(in_tdata[ID_W-1:0]);
  assign rda_id_ext  = 32'(h_rda.id);
  assign item_id_ext = 32'(item_r.id);
  assign left_c      = {idx_r, 1'b1};
  assign right_c     = left_c + (CW+1)'(1);
  assign parent_c    = (idx_r - CW'(1)) >> 1;
  assign right_pick  = (right_c < (CW+1)'(cnt_r)) && earlier(h_rdb.ex, h_rda.ex);
  assign child_c     = right_pick ? h_rdb : h_rda;
  assign diff_c      = h_rda.ex - now_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    now_nxt       = now_r;
    func_nxt      = func_r;
    id_nxt        = id_r;
    ex_nxt        = ex_r;
    kind_nxt      = kind_r;
    pop_nxt       = pop_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_pend_nxt  = out_pend_r;
    out_next_nxt  = out_next_r;
    out_last_nxt  = out_last_r;
    h_rd_en       = 1'b0;
    h_ra          = '0;
    h_rb          = '0;
    h_we          = 1'b0;
    h_wa          = idx_r[HAW-1:0];
    h_wd          = h_rda;
    p_rd_en       = 1'b0;
    p_ra          = in_id_ext[PAW-1:0];
    p_we          = 1'b0;
    p_wa          = rda_id_ext[PAW-1:0];
    p_wd          = idx_r[HAW-1:0];
    in_tready     = 1'b0;

    unique case (state_r)
      S_CLR: begin
        p_we = 1'b1;
        p_wa = clr_r;
        p_wd = '0;
        clr_nxt = clr_r + PAW'(1);
        if (clr_r == PAW'(ID_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt = in_tuser;
          id_nxt   = in_tdata[ID_W-1:0];
          ex_nxt   = now_r + EX_W'(in_tdata[ID_W +: TMO_W]);
          kind_nxt = K_DONE;
          pop_nxt  = 1'b0;
          unique case (in_tuser)
            F_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_FIN0;
            end
            F_TICK: begin
              now_nxt   = now_r + EX_W'(1);
              pop_nxt   = 1'b1;
              state_nxt = S_POPR;
            end
            default: begin
              if (in_id_ext >= 32'(ID_COUNT)) begin
                kind_nxt  = K_NOT_FOUND;
                state_nxt = S_FIN0;
              end else begin
                p_rd_en   = 1'b1;
                state_nxt = S_LK1;
              end
            end
          endcase
        end
      end
      S_LK1: begin
        h_rd_en   = 1'b1;
        h_ra      = p_rd;
        state_nxt = S_LK2;
      end
      S_LK2: begin
        // The id is present when its mapped slot is live and holds that id.
        if ((CW'(p_rd) < cnt_r) && (h_rda.id == id_r)) begin
          item_nxt  = '{id: id_r, ex: ex_r};
          idx_nxt   = CW'(p_rd);
          state_nxt = S_UP;
        end else if (func_r == F_ADJUST) begin
          kind_nxt  = K_NOT_FOUND;
          state_nxt = S_FIN0;
        end else if (cnt_r == CW'(HEAP_DEPTH)) begin
          kind_nxt  = K_FULL;
          state_nxt = S_FIN0;
        end else begin
          item_nxt  = '{id: id_r, ex: ex_r};
          idx_nxt   = cnt_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (idx_r == '0) begin
          state_nxt = S_DN;
        end else begin
          h_rd_en   = 1'b1;
          h_ra      = parent_c[HAW-1:0];
          state_nxt = S_UP2;
        end
      end
      S_UP2: begin
        if (earlier(h_rda.ex, item_r.ex)) begin
          state_nxt = S_DN;
        end else begin
          h_we      = 1'b1;
          h_wd      = h_rda;
          p_we      = 1'b1;
          p_wa      = rda_id_ext[PAW-1:0];
          idx_nxt   = parent_c;
          state_nxt = S_UP;
        end
      end
      S_DN: begin
        if (left_c >= (CW+1)'(cnt_r)) begin
          state_nxt = S_WB;
        end else begin
          h_rd_en   = 1'b1;
          h_ra      = left_c[HAW-1:0];
          h_rb      = right_c[HAW-1:0];
          state_nxt = S_DN2;
        end
      end
      S_DN2: begin
        if (!earlier(child_c.ex, item_r.ex)) begin
          state_nxt = S_WB;
        end else begin
          h_we      = 1'b1;
          h_wd      = child_c;
          p_we      = 1'b1;
          p_wa      = PAW'(32'(child_c.id));
          idx_nxt   = right_pick ? CW'(right_c) : CW'(left_c);
          state_nxt = S_DN;
        end
      end
      S_WB: begin
        h_we      = 1'b1;
        h_wd      = item_r;
        p_we      = 1'b1;
        p_wa      = item_id_ext[PAW-1:0];
        state_nxt = pop_r ? S_POPR : S_FIN0;
      end
      S_POPR: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN0;
        end else begin
          h_rd_en   = 1'b1;
          h_ra      = '0;
          h_rb      = HAW'(cnt_r - CW'(1));
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (diff_c != '0 && !diff_c[EX_W-1]) begin
          state_nxt = S_FIN0;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_EXPIRED;
          out_id_nxt    = h_rda.id;
          out_pend_nxt  = 1'b0;
          out_next_nxt  = '0;
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_FIN0;
          end else begin
            // The last slot moves to the root and sifts down.
            item_nxt  = h_rdb;
            idx_nxt   = '0;
            state_nxt = S_DN;
          end
        end
      end
      S_FIN0: begin
        h_rd_en   = 1'b1;
        h_ra      = '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_id_nxt    = '0;
          out_pend_nxt  = (cnt_r != '0);
          out_last_nxt  = 1'b1;
          if (cnt_r == '0 || diff_c[EX_W-1]) begin
            out_next_nxt = '0;
          end else if (diff_c > EX_W'(16'hFFFF)) begin
            out_next_nxt = 16'hFFFF;
          end else begin
            out_next_nxt = diff_c[15:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      now_r       <= '0;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      now_r       <= now_nxt;
      pop_r       <= pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    id_r       <= id_nxt;
    ex_r       <= ex_nxt;
    kind_r     <= kind_nxt;
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_pend_r <= out_pend_nxt;
    out_next_r <= out_next_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'b0, out_next_r, out_pend_r, out_id_r};
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HEAP_DEPTH))
    else $error("entry count beyond heap depth");

  a_mid_is_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == K_EXPIRED)
    else $error("non-final result that is not an expiry");

  a_mid_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[26:10] == 17'd0)
    else $error("non-final result carries queue status");

  a_idle_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while one is in work");

endmodule

/* design/mhtq_heap_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_heap_mem
// Heap slot store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mhtq_heap_mem
  import mhtq_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int HAW        = $clog2(HEAP_DEPTH)
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [HAW-1:0] rda_addr,
  input  logic [HAW-1:0] rdb_addr,
  output entry_t         rda_data,
  output entry_t         rdb_data,
  input  logic           wr_en,
  input  logic [HAW-1:0] wr_addr,
  input  entry_t         wr_data
);

  entry_t mem [HEAP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rda_data <= mem[rda_addr];
      rdb_data <= mem[rdb_addr];
    end
  end

endmodule

/* design/mhtq_pos_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_pos_mem
// Map from timer id to heap slot: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mhtq_pos_mem
  import mhtq_pkg::*;
#(
  parameter int ID_COUNT = ID_COUNT_DEF,
  parameter int PAW      = $clog2(ID_COUNT),
  parameter int HAW      = $clog2(HEAP_DEPTH_DEF)
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [PAW-1:0] rd_addr,
  output logic [HAW-1:0] rd_data,
  input  logic           wr_en,
  input  logic [PAW-1:0] wr_addr,
  input  logic [HAW-1:0] wr_data
);

  logic [HAW-1:0] mem [ID_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the min-heap timer queue against its own heap predictor.
// Adds, adjusts, ticks and clears go in at random rates, with directed cases
// first. Every result, expired ids and final status alike, is compared with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import mhtq_pkg::*;

  localparam int DEPTH = HEAP_DEPTH_DEF;
  localparam int NIDS  = ID_COUNT_DEF;

  typedef struct {
    logic [1:0]  kind;
    logic [9:0]  xid;
    logic        pend;
    logic [15:0] due;
    logic        lst;
  } timer_result_t;

  class timer_scoreboard;
    logic [9:0]  slot_id[DEPTH];
    logic [31:0] slot_ex[DEPTH];
    int          slot_of[NIDS];
    bit          present[NIDS];
    int          count;
    logic [31:0] clock_ms;
    timer_result_t expected_results[$];
    int          errors;

    function void clear_state();
      foreach (present[i]) present[i] = 0;
      count = 0;
      clock_ms = 0;
      errors = 0;
    endfunction

    function bit before_ex(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function void swap_slots(int i, int j);
      logic [9:0]  t_id;
      logic [31:0] t_ex;
      t_id = slot_id[i]; t_ex = slot_ex[i];
      slot_id[i] = slot_id[j]; slot_ex[i] = slot_ex[j];
      slot_id[j] = t_id; slot_ex[j] = t_ex;
      slot_of[slot_id[i]] = i;
      slot_of[slot_id[j]] = j;
    endfunction

    function int rise(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (before_ex(slot_ex[p], slot_ex[i])) break;
        swap_slots(i, p);
        i = p;
      end
      return i;
    endfunction

    function void sink(int i);
      int l;
      int c;
      forever begin
        l = 2 * i + 1;
        if (l >= count) break;
        c = l;
        if (l + 1 < count && before_ex(slot_ex[l + 1], slot_ex[l])) c = l + 1;
        if (!before_ex(slot_ex[c], slot_ex[i])) break;
        swap_slots(i, c);
        i = c;
      end
    endfunction

    function void add_expected(logic [1:0] kind, logic [9:0] xid, bit fin);
      timer_result_t r;
      logic [31:0] d;
      r.kind = kind; r.xid = xid; r.lst = fin; r.pend = 0; r.due = 0;
      if (fin) begin
        r.pend = count > 0;
        if (count > 0) begin
          d = slot_ex[0] - clock_ms;
          if (!d[31]) r.due = d > 32'hFFFF ? 16'hFFFF : d[15:0];
        end
      end
      expected_results = {expected_results, r};
    endfunction

    function void note_request(logic [1:0] func, logic [9:0] tid, logic [15:0] tmo);
      logic [31:0] ex;
      logic [31:0] d;
      logic [9:0]  gone;
      int p;
      case (func)
        F_ADD, F_ADJUST: begin
          ex = clock_ms + 32'(tmo);
          if (present[tid]) begin
            p = slot_of[tid];
            slot_ex[p] = ex;
            p = rise(p);
            sink(p);
            add_expected(K_DONE, 10'd0, 1'b1);
          end else if (func == F_ADJUST) begin
            add_expected(K_NOT_FOUND, 10'd0, 1'b1);
          end else if (count >= DEPTH) begin
            add_expected(K_FULL, 10'd0, 1'b1);
          end else begin
            slot_id[count] = tid;
            slot_ex[count] = ex;
            slot_of[tid] = count;
            present[tid] = 1;
            count++;
            p = rise(count - 1);
            add_expected(K_DONE, 10'd0, 1'b1);
          end
        end
        F_TICK: begin
          clock_ms++;
          while (count > 0) begin
            d = slot_ex[0] - clock_ms;
            if (d != 0 && !d[31]) break;
            gone = slot_id[0];
            add_expected(K_EXPIRED, gone, 1'b0);
            count--;
            if (count > 0) swap_slots(0, count);
            present[gone] = 0;
            sink(0);
          end
          add_expected(K_DONE, 10'd0, 1'b1);
        end
        default: begin
          foreach (present[i]) present[i] = 0;
          count = 0;
          add_expected(K_DONE, 10'd0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [31:0] data, logic fin);
      timer_result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d data=%h", kind, data);
        return;
      end
      e = expected_results.pop_front();
      if (kind !== e.kind || data[9:0] !== e.xid || data[10] !== e.pend ||
          data[26:11] !== e.due || fin !== e.lst || data[31:27] !== 0) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch exp kind=%0d id=%0d pend=%0d due=%0d last=%0d",
                    " / act kind=%0d id=%0d pend=%0d due=%0d last=%0d"},
                   e.kind, e.xid, e.pend, e.due, e.lst,
                   kind, data[9:0], data[10], data[26:11], fin);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  timer_scoreboard sb;
  bit  idle_on;
  int  quiet_cycles;
  logic [9:0] recent_ids[8];

  min_heap_timer_queue_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Accepted requests feed the predictor; accepted results are checked.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser, in_tdata[9:0], in_tdata[25:10]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      out_tready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    end
  end

  // Counts cycles with no handshake; the clearing sweep after reset fits easily.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] func, logic [9:0] tid, logic [15:0] tmo);
    while (idle_on && $urandom_range(99) < 36) @(posedge clk);
    in_tvalid <= 1;
    in_tuser  <= func;
    in_tdata  <= {6'd0, tmo, tid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 0;
    // The block is busy after a request anyway.
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_timeout();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(12));
    if (r < 90) return 16'($urandom_range(60));
    return 16'($urandom);
  endfunction

  function automatic logic [9:0] pick_id();
    if ($urandom_range(99) < 60) return recent_ids[$urandom_range(7)];
    return 10'($urandom);
  endfunction

  initial begin
    int r;
    sb = new();
    sb.clear_state();
    foreach (recent_ids[i]) recent_ids[i] = 10'($urandom);
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = F_ADD;
    idle_on = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Directed: empty cases, extreme ids and timeouts, ties, refresh, full heap.
    send_request(F_TICK, 0, 0);
    send_request(F_ADJUST, 10'd5, 16'd3);
    send_request(F_ADD, 10'd0, 16'd0);
    send_request(F_ADD, 10'd1023, 16'hFFFF);
    send_request(F_ADD, 10'd7, 16'd2);
    send_request(F_ADD, 10'd8, 16'd2);
    send_request(F_ADD, 10'h155, 16'h5555);
    send_request(F_ADD, 10'h2AA, 16'hAAAA);
    send_request(F_ADJUST, 10'd1023, 16'd1);
    send_request(F_ADD, 10'd7, 16'd40);
    send_request(F_TICK, 0, 0);
    send_request(F_TICK, 0, 0);
    send_request(F_TICK, 0, 0);
    send_request(F_CLEAR, 0, 0);
    send_request(F_TICK, 0, 0);
    for (int i = 0; i < DEPTH; i++) send_request(F_ADD, 10'(100 + i), 16'(i % 3 + 1));
    send_request(F_ADD, 10'd900, 16'd1);
    send_request(F_ADD, 10'd100, 16'd5);
    send_request(F_TICK, 0, 0);
    send_request(F_TICK, 0, 0);
    wait_drained();

    // Random: long no-idle stretch first, then random idling on both sides.
    for (int n = 0; n < 260; n++) begin
      idle_on = n >= 80;
      if (n == 200) wait_drained();
      r = $urandom_range(99);
      if (r < 45) begin
        send_request(F_ADD, pick_id(), pick_timeout());
        if ($urandom_range(3) == 0) recent_ids[$urandom_range(7)] = 10'($urandom);
      end else if (r < 60) send_request(F_ADJUST, pick_id(), pick_timeout());
      else if (r < 97) send_request(F_TICK, 10'($urandom), 16'($urandom));
      else send_request(F_CLEAR, 10'($urandom), 16'($urandom));
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
